>>> rtl/b8enc_pkg.sv
package b8enc_pkg;

    localparam int unsigned C_ALPHA_W = 63;
    localparam int unsigned C_DATA_W  = 64;
    localparam int unsigned C_ADDR_W  = 4;

    localparam logic [C_ALPHA_W-1:0] C_ALPHABET_RESET = 63'h6365_746E_616D_7973;
    localparam logic [7:0]           C_PAD_RESET      = 8'h24;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;

    // Register index as seen on paddr[3] (registers sit at 8*i).
    localparam logic C_REG_ALPHABET = 1'b0;
    localparam logic C_REG_PAD      = 1'b1;

    // One classified byte: the 3-bit codes it releases, the pads that follow
    // and whether it closes the line.
    typedef struct packed {
        logic [3:0][2:0] codes;
        logic [2:0]      n_codes;
        logic [2:0]      n_pads;
        logic            eol;
    } t_job;

endpackage

>>> rtl/b8enc_front.sv
module b8enc_front
    import b8enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_end,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0] r_left, n_left;
    logic [1:0] r_cnt, n_cnt;
    logic       r_start, n_start;

    logic       accept;
    logic       skip;
    logic [9:0] acc;
    t_job       job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    // Leading blanks are swallowed; a blank with line_end just ends an empty line.
    assign skip    = r_start && ((i_data_byte == C_SPACE) || (i_data_byte == C_TAB));
    assign acc     = {r_left, i_data_byte};

    // The bit count left over also tells the position within a 3-byte group:
    // 2 bits after one byte, 1 bit after two, none after three.
    always_comb begin
        job        = '0;
        job.eol    = i_line_end;
        n_left     = 2'd0;
        n_cnt      = 2'd0;
        case (r_cnt)
            2'd2: begin
                job.codes[0] = acc[9:7];
                job.codes[1] = acc[6:4];
                job.codes[2] = acc[3:1];
                job.codes[3] = {acc[0], 2'b00};
                job.n_codes  = 3'd3;
                n_left       = {1'b0, acc[0]};
                n_cnt        = 2'd1;
                if (i_line_end) begin
                    job.n_codes = 3'd4;
                    job.n_pads  = 3'd2;
                end
            end
            2'd1: begin
                job.codes[0] = acc[8:6];
                job.codes[1] = acc[5:3];
                job.codes[2] = acc[2:0];
                job.n_codes  = 3'd3;
            end
            default: begin
                job.codes[0] = acc[7:5];
                job.codes[1] = acc[4:2];
                job.codes[2] = {acc[1:0], 1'b0};
                job.n_codes  = 3'd2;
                n_left       = acc[1:0];
                n_cnt        = 2'd2;
                if (i_line_end) begin
                    job.n_codes = 3'd3;
                    job.n_pads  = 3'd5;
                end
            end
        endcase
    end

    assign o_push = accept && !skip;
    assign o_job  = job;

    always_comb begin
        n_start = r_start;
        if (accept && !skip) begin
            n_start = i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 2'd0;
            r_cnt   <= 2'd0;
            r_start <= 1'b1;
        end else begin
            r_start <= n_start;
            if (accept && !skip) begin
                r_left <= i_line_end ? 2'd0 : n_left;
                r_cnt  <= i_line_end ? 2'd0 : n_cnt;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("leftover bit count out of range");
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_cnt == 2'd0 && r_left == 2'd0))
        else $error("line start with leftover bits");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into full queue");

endmodule

>>> rtl/b8enc_fifo.sv
module b8enc_fifo
    import b8enc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/b8enc_back.sv
module b8enc_back
    import b8enc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_job                 i_job,
    output logic                 o_pop,
    input  logic [C_ALPHA_W-1:0] i_alphabet,
    input  logic [7:0]           i_pad_char,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_symbol,
    output logic                 o_last
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_symbol;
    logic       r_last;

    logic [3:0]  total;
    logic        is_final;
    logic        load;
    logic [2:0]  code;
    logic [63:0] alpha64;
    logic [7:0]  sym;

    assign total    = {1'b0, i_job.n_codes} + {1'b0, i_job.n_pads};
    assign is_final = ({1'b0, r_idx} == (total - 4'd1));
    assign load     = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop    = load && is_final;

    assign alpha64 = {1'b0, i_alphabet};
    assign code    = i_job.codes[r_idx[1:0]];

    always_comb begin
        if (r_idx < i_job.n_codes) begin
            sym = alpha64[{code, 3'b000} +: 8];
        end else begin
            sym = i_pad_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_symbol <= sym;
            r_last   <= i_job.eol && is_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_final ? 3'd0 : (r_idx + 3'd1);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> ({1'b0, r_idx} < total))
        else $error("symbol index beyond job length");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == 3'd0))
        else $error("symbol index left over without a job");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_job.eol |=> (o_valid && o_last))
        else $error("line end did not flag the last symbol");

endmodule

>>> rtl/base8_text_encoder_unit.sv
// Base-8 text encoder. Bytes of a line enter on i_valid/o_ready, leading spaces
// and tabs are dropped, and each byte is encoded MSB first as 3-bit groups that
// pick characters from the alphabet register; at line end a partial group is
// zero-filled and pad characters follow so that each 3-byte group yields eight
// symbols, the final one flagged by o_last. Symbols leave from an output
// register at one per cycle while i_ready holds; a byte yields 2 or 3 symbols
// mid-line and up to 8 on the line's final byte. The input side classifies a
// byte combinationally and hands it to a two-entry queue, so it keeps
// accepting bytes while the output drains until the queue is full; the first
// symbol passes through the queue and then the output register. Registers are
// written over the APB port with 64-bit data: alphabet at 0x0 (symbol k in
// byte k, 63 bits) and pad_char at 0x8. Registers should be written only when
// no line is in flight.
module base8_text_encoder_unit
    import b8enc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [C_ADDR_W-1:0] paddr,
    input  logic [C_DATA_W-1:0] pwdata,
    output logic [C_DATA_W-1:0] prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_line_end,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_symbol,
    output logic                o_last
);

    logic [C_ALPHA_W-1:0] r_alphabet;
    logic [7:0]           r_pad_char;
    logic                 wr_en;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job head_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet <= C_ALPHABET_RESET;
            r_pad_char <= C_PAD_RESET;
        end else if (wr_en) begin
            if (paddr[3] == C_REG_ALPHABET) begin
                r_alphabet <= pwdata[C_ALPHA_W-1:0];
            end else begin
                r_pad_char <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        case (paddr[3])
            C_REG_ALPHABET: prdata = {1'b0, r_alphabet};
            C_REG_PAD:      prdata = {56'd0, r_pad_char};
            default:        prdata = '0;
        endcase
    end

    b8enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_line_end  (i_line_end),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    b8enc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b8enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .i_alphabet (r_alphabet),
        .i_pad_char (r_pad_char),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_symbol   (o_symbol),
        .o_last     (o_last)
    );

endmodule

>>> test/tb.sv
module tb;
    import b8enc_pkg::*;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_sym;

    // One row of the directed table. n_want = 0 leaves the row to the encoder
    // model below; otherwise want holds the symbols right-aligned, first
    // symbol leftmost.
    typedef struct packed {
        logic [7:0]  data;
        logic        eol;
        logic [3:0]  n_want;
        logic [63:0] want;
    } t_dir_row;

    localparam int N_DIR = 23;
    localparam int N_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 28;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [C_ADDR_W-1:0] paddr;
    logic [C_DATA_W-1:0] pwdata;
    logic [C_DATA_W-1:0] prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic [7:0]          i_data_byte;
    logic                i_line_end;
    logic                o_valid;
    logic                i_ready;
    logic [7:0]          o_symbol;
    logic                o_last;

    // Encoder model state and its copy of the registers.
    logic [C_ALPHA_W-1:0] alpha_reg;
    logic [7:0]           pad_reg;
    logic [1:0]           carry_bits;
    logic [1:0]           carry_cnt;
    logic [1:0]           grp_pos;
    logic                 line_start;

    t_sym        pending_syms [$];
    int          err_count = 0;
    bit          no_idle = 1'b0;
    logic [3:0]  typed_n = '0;
    logic [63:0] typed_syms = '0;
    int          n_before;
    t_sym        e;

    t_dir_row dir_rows [N_DIR] = '{
        '{8'h00, 1'b1, 4'd8, "sss$$$$$"},
        '{8'hFF, 1'b1, 4'd8, "cce$$$$$"},
        '{8'h0A, 1'b1, 4'd8, "smn$$$$$"},
        '{C_SPACE, 1'b1, 4'd0, 64'd0},
        '{C_TAB, 1'b1, 4'd0, 64'd0},
        '{8'hFF, 1'b0, 4'd2, 64'("cc")},
        '{8'hFF, 1'b0, 4'd3, 64'("ccc")},
        '{8'hFF, 1'b1, 4'd3, 64'("ccc")},
        '{C_SPACE, 1'b0, 4'd0, 64'd0},
        '{C_TAB, 1'b0, 4'd0, 64'd0},
        '{8'h41, 1'b0, 4'd0, 64'd0},
        '{C_SPACE, 1'b0, 4'd0, 64'd0},
        '{C_TAB, 1'b1, 4'd0, 64'd0},
        '{8'h80, 1'b0, 4'd0, 64'd0},
        '{8'h01, 1'b0, 4'd0, 64'd0},
        '{8'h7F, 1'b0, 4'd0, 64'd0},
        '{8'hFE, 1'b1, 4'd0, 64'd0},
        '{8'h55, 1'b0, 4'd0, 64'd0},
        '{8'hAA, 1'b1, 4'd0, 64'd0},
        '{8'h41, 1'b0, 4'd0, 64'd0},
        '{C_SPACE, 1'b1, 4'd0, 64'd0},
        '{C_TAB, 1'b0, 4'd0, 64'd0},
        '{C_SPACE, 1'b1, 4'd0, 64'd0}
    };

    base8_text_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_line_end  (i_line_end),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR: %s: got 0x%h, want 0x%h", what, got, want);
        err_count++;
    endtask

    function automatic void add_sym(input t_sym s);
        pending_syms = {pending_syms, s};
    endfunction

    function automatic logic [7:0] alpha_sym(input logic [2:0] code);
        logic [63:0] a;
        a = {1'b0, alpha_reg};
        return a[8*code +: 8];
    endfunction

    function automatic void clear_line();
        carry_bits = '0;
        carry_cnt  = '0;
        grp_pos    = '0;
        line_start = 1'b1;
    endfunction

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 1) != 0) ? C_SPACE : C_TAB;
    endfunction

    // Appends the symbols one accepted byte releases to pending_syms.
    function automatic void encode_byte(input logic [7:0] b, input logic eol);
        logic [9:0] acc;
        int         nbits;
        int         in_grp;
        int         n_pad;
        t_sym       s;
        if (line_start && (b == C_SPACE || b == C_TAB)) begin
            if (eol)
                clear_line();
            return;
        end
        line_start = 1'b0;
        acc = {carry_bits, b};
        nbits = int'(carry_cnt) + 8;
        s.last = 1'b0;
        while (nbits >= 3) begin
            nbits -= 3;
            s.symbol = alpha_sym(3'(acc >> nbits));
            add_sym(s);
        end
        carry_bits = 2'(acc & ((10'd1 << nbits) - 10'd1));
        carry_cnt  = 2'(nbits);
        grp_pos    = (grp_pos == 2'd2) ? 2'd0 : grp_pos + 2'd1;
        if (eol) begin
            // A partial group is filled with zeros at the bottom.
            if (carry_cnt != 0) begin
                s.symbol = alpha_sym(3'(int'(carry_bits) << (3 - int'(carry_cnt))));
                add_sym(s);
            end
            in_grp = (grp_pos == 2'd0) ? 3 : int'(grp_pos);
            n_pad = 8 - (in_grp * 8 + 2) / 3;
            s.symbol = pad_reg;
            repeat (n_pad) add_sym(s);
            s = pending_syms.pop_back();
            s.last = 1'b1;
            add_sym(s);
            clear_line();
        end
    endfunction

    // Output check first, then prediction for the byte taken at this edge, so
    // the order of processes within the time step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_syms.size() == 0) begin
                report_mismatch("symbol with nothing pending", o_symbol, 8'h00);
            end else begin
                e = pending_syms.pop_front();
                if (o_symbol !== e.symbol)
                    report_mismatch("symbol", o_symbol, e.symbol);
                if (o_last !== e.last)
                    report_mismatch("last flag", {7'd0, o_last}, {7'd0, e.last});
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            n_before = pending_syms.size();
            encode_byte(i_data_byte, i_line_end);
            if (typed_n != 0) begin
                while (pending_syms.size() > n_before)
                    void'(pending_syms.pop_back());
                for (int k = 0; k < int'(typed_n); k++) begin
                    e.symbol = typed_syms[8*(int'(typed_n)-1-k) +: 8];
                    e.last   = i_line_end && (k == int'(typed_n) - 1);
                    add_sym(e);
                end
            end
        end
    end

    // Symbol consumer: random stall before each transaction.
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eol,
                             input logic [3:0] n_want, input logic [63:0] want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_line_end  <= eol;
        typed_n     <= n_want;
        typed_syms  <= want;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [C_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == C_REG_ALPHABET)
            alpha_reg = value[C_ALPHA_W-1:0];
        else
            pad_reg = value[7:0];
    endtask

    // A blank line yields nothing, so give the block time to finish it too.
    task automatic wait_idle();
        while (pending_syms.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int         items_done;
        int         body_len;
        int         n_lead;
        logic [7:0] b;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_line_end  = 1'b0;
        alpha_reg   = C_ALPHABET_RESET;
        pad_reg     = C_PAD_RESET;
        clear_line();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++)
            send_byte(dir_rows[r].data, dir_rows[r].eol, dir_rows[r].n_want,
                      dir_rows[r].want);
        i_valid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: begin
                    cfg_write(C_REG_ALPHABET, {1'b0, {C_ALPHA_W{1'b1}}});
                    cfg_write(C_REG_PAD, 64'hFF);
                end
                2: begin
                    cfg_write(C_REG_ALPHABET, 64'd0);
                    cfg_write(C_REG_PAD, 64'd0);
                end
                3, 4: begin
                    cfg_write(C_REG_ALPHABET, {1'b0, 31'($urandom), $urandom});
                    cfg_write(C_REG_PAD, 64'($urandom_range(0, 255)));
                end
                5: begin
                    cfg_write(C_REG_ALPHABET, {1'b0, C_ALPHABET_RESET});
                    cfg_write(C_REG_PAD, 64'(C_PAD_RESET));
                end
                default: ;
            endcase
            items_done = 0;
            while (items_done < ITEMS_PER_PHASE) begin
                no_idle = ($urandom_range(0, 5) == 0);
                n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                repeat (n_lead) send_byte(pick_blank(), 1'b0, 4'd0, 64'd0);
                items_done += n_lead;
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(pick_blank(), 1'b1, 4'd0, 64'd0);
                    items_done += 1;
                end else begin
                    body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                           : $urandom_range(1, 7);
                    for (int k = 0; k < body_len; k++) begin
                        b = ($urandom_range(0, 7) == 0) ? pick_blank()
                                                        : 8'($urandom_range(0, 255));
                        send_byte(b, k == body_len - 1, 4'd0, 64'd0);
                    end
                    items_done += body_len;
                end
            end
            i_valid <= 1'b0;
            no_idle = 1'b0;
            wait_idle();
        end

        if (err_count == 0 && pending_syms.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Far beyond the slowest legal run: every byte stalled on both sides.
    initial begin
        #(8 * 100000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/b8enc_pkg.sv
rtl/b8enc_front.sv
rtl/b8enc_fifo.sv
rtl/b8enc_back.sv
rtl/base8_text_encoder_unit.sv
test/tb.sv
